@@ hw/rtl/nlsp_pkg.sv @@
// nlsp_pkg: shared types and constants for the nested list string parser
// used by nested_list_string_parser and nlsp_checker; no dependencies

package nlsp_pkg;

    localparam int unsigned MAX_STRING_CHARS = 128;
    localparam int unsigned MAX_ENTRIES      = 1024;

    localparam int unsigned LEN_W  = 8;
    localparam int unsigned CNT_W  = 10;
    localparam int unsigned HASH_W = 64;

    localparam logic [HASH_W-1:0] HASH_SEED = 64'd5381;

    // result kinds
    typedef enum logic [2:0] {
        RK_CHAR  = 3'd0,
        RK_END   = 3'd1,
        RK_HASH  = 3'd2,
        RK_COUNT = 3'd3,
        RK_ERROR = 3'd4
    } rk_t;

    // error codes
    typedef enum logic [3:0] {
        ERR_TOO_DEEP     = 4'd0,
        ERR_EXTRA_CLOSE  = 4'd1,
        ERR_FEW_VALUES   = 4'd2,
        ERR_BAD_QUOTE    = 4'd3,
        ERR_BAD_COMMA    = 4'd4,
        ERR_BAD_CHAR     = 4'd5,
        ERR_BAD_ESCAPE   = 4'd6,
        ERR_TOO_LONG     = 4'd7,
        ERR_TOO_MANY     = 4'd8,
        ERR_NONE         = 4'd15
    } err_t;

    // value slots
    localparam logic [1:0] SLOT_KEY    = 2'd0;
    localparam logic [1:0] SLOT_NAME   = 2'd1;
    localparam logic [1:0] SLOT_IMAGE  = 2'd2;
    localparam logic [1:0] SLOT_BEYOND = 2'd3;

    // characters
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_V      = 8'h76;
    localparam logic [7:0] CH_NUL    = 8'h00;

endpackage

@@ hw/rtl/nested_list_string_parser.sv @@
// nested_list_string_parser: byte-stream parser for a list of string arrays
// depends on nlsp_pkg
//
//   channel | handshake            | fields
//   --------+----------------------+-----------------------------------------------
//   request | req_valid, req_ready | kind, byte_req
//   result  | res_valid, res_ready | result_kind, entry_number, value_slot, payload,
//           |                      | error_code
//
// one byte per cycle while req_ready is high: parse state and the 64-bit shift-add
// hash step are updated in the accepting cycle, the result appears in the output
// register on the next cycle. req_ready is high while the output register is
// empty or being taken, so a stalled result holds the input only when it stays.
// rst_n clears all parse state and the hash to its seed; after an error or
// the end marker the parser drops every byte until reset.

module nested_list_string_parser
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        req_valid,
    output logic        req_ready,
    input  logic        kind,
    input  logic [7:0]  byte_req,

    output logic        res_valid,
    input  logic        res_ready,
    output logic [2:0]  result_kind,
    output logic [9:0]  entry_number,
    output logic [1:0]  value_slot,
    output logic [63:0] payload,
    output logic [3:0]  error_code
);

    logic [1:0]                     depth_reg, depth_next;
    logic                           in_str_reg, in_str_next;
    logic                           entry_open_reg, entry_open_next;
    logic [nlsp_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic [1:0]                     pos_reg, pos_next;
    logic                           done_reg, done_next;
    logic [nlsp_pkg::LEN_W-1:0]     len_reg, len_next;
    logic                           esc_reg, esc_next;
    logic [nlsp_pkg::HASH_W-1:0]    hash_reg, hash_next;
    logic                           halted_reg, halted_next;
    logic                           hstop_reg, hstop_next;
    logic                           res_valid_reg, res_valid_next;

    nlsp_pkg::rk_t                  rk_reg, rk_next;
    logic [nlsp_pkg::CNT_W-1:0]     num_reg;
    logic [1:0]                     slot_reg, slot_next;
    logic [nlsp_pkg::HASH_W-1:0]    pl_reg, pl_next;
    nlsp_pkg::err_t                 ec_reg, ec_next;

    logic                           accept;
    logic                           emit;
    logic                           fail;
    nlsp_pkg::err_t                 fail_code;
    logic                           add_en;
    logic [7:0]                     add_c;
    logic [7:0]                     esc_c;
    logic                           esc_ok;
    logic                           stop;

    assign req_ready = !res_valid_reg || res_ready;
    assign accept    = req_valid && req_ready;

    // escape decode
    always_comb
    begin
        esc_ok = 1'b1;
        unique case (byte_req)
            nlsp_pkg::CH_QUOTE:  esc_c = nlsp_pkg::CH_QUOTE;
            nlsp_pkg::CH_N:      esc_c = nlsp_pkg::CH_LF;
            nlsp_pkg::CH_R:      esc_c = nlsp_pkg::CH_CR;
            nlsp_pkg::CH_T:      esc_c = nlsp_pkg::CH_TAB;
            nlsp_pkg::CH_V:      esc_c = nlsp_pkg::CH_VT;
            nlsp_pkg::CH_APOS:   esc_c = nlsp_pkg::CH_APOS;
            nlsp_pkg::CH_BSLASH: esc_c = nlsp_pkg::CH_BSLASH;
            default:
            begin
                esc_c  = nlsp_pkg::CH_NUL;
                esc_ok = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        depth_next      = depth_reg;
        in_str_next     = in_str_reg;
        entry_open_next = entry_open_reg;
        cnt_next        = cnt_reg;
        pos_next        = pos_reg;
        done_next       = done_reg;
        len_next        = len_reg;
        esc_next        = esc_reg;
        hash_next       = hash_reg;
        halted_next     = halted_reg;
        hstop_next      = hstop_reg;

        emit      = 1'b0;
        rk_next   = nlsp_pkg::RK_CHAR;
        slot_next = pos_reg;
        pl_next   = '0;
        ec_next   = nlsp_pkg::ERR_NONE;
        fail      = 1'b0;
        fail_code = nlsp_pkg::ERR_TOO_DEEP;
        add_en    = 1'b0;
        add_c     = byte_req;
        stop      = hstop_reg;

        if (accept && !halted_reg)
        begin
            if (kind)
            begin
                if (esc_reg)
                begin
                    fail      = 1'b1;
                    fail_code = nlsp_pkg::ERR_BAD_ESCAPE;
                end
                else
                begin
                    halted_next = 1'b1;
                    emit        = 1'b1;
                    rk_next     = nlsp_pkg::RK_COUNT;
                    slot_next   = nlsp_pkg::SLOT_KEY;
                    pl_next     = nlsp_pkg::HASH_W'(cnt_reg) + 64'd1;
                end
            end
            else if (esc_reg)
            begin
                esc_next = 1'b0;
                if (!esc_ok)
                begin
                    fail      = 1'b1;
                    fail_code = nlsp_pkg::ERR_BAD_ESCAPE;
                end
                else
                begin
                    add_en = 1'b1;
                    add_c  = esc_c;
                end
            end
            else
            begin
                unique case (byte_req)
                    nlsp_pkg::CH_LBRACK:
                    begin
                        if (depth_reg >= 2'd2)
                        begin
                            fail      = 1'b1;
                            fail_code = nlsp_pkg::ERR_TOO_DEEP;
                        end
                        else
                        begin
                            depth_next = depth_reg + 2'd1;
                            if (depth_reg == 2'd1)
                                entry_open_next = 1'b1;
                        end
                    end
                    nlsp_pkg::CH_RBRACK:
                    begin
                        if (depth_reg == 2'd0)
                        begin
                            fail      = 1'b1;
                            fail_code = nlsp_pkg::ERR_EXTRA_CLOSE;
                        end
                        else if (depth_reg == 2'd2 && pos_reg < nlsp_pkg::SLOT_IMAGE)
                        begin
                            fail      = 1'b1;
                            fail_code = nlsp_pkg::ERR_FEW_VALUES;
                        end
                        else
                        begin
                            depth_next = depth_reg - 2'd1;
                            if (depth_reg == 2'd2)
                                entry_open_next = 1'b0;
                            pos_next  = nlsp_pkg::SLOT_KEY;
                            done_next = 1'b0;
                        end
                    end
                    nlsp_pkg::CH_QUOTE:
                    begin
                        in_str_next = !in_str_reg;
                        if (!in_str_reg)
                        begin
                            if (done_reg)
                            begin
                                fail      = 1'b1;
                                fail_code = nlsp_pkg::ERR_BAD_QUOTE;
                            end
                        end
                        else
                        begin
                            hash_next  = nlsp_pkg::HASH_SEED;
                            hstop_next = 1'b0;
                            len_next   = '0;
                            done_next  = 1'b1;
                            if (pos_reg == nlsp_pkg::SLOT_KEY)
                            begin
                                emit    = 1'b1;
                                rk_next = nlsp_pkg::RK_HASH;
                                pl_next = hash_reg;
                            end
                            else if (pos_reg != nlsp_pkg::SLOT_BEYOND)
                            begin
                                emit    = 1'b1;
                                rk_next = nlsp_pkg::RK_END;
                            end
                        end
                    end
                    nlsp_pkg::CH_COMMA:
                    begin
                        if (entry_open_reg && !done_reg)
                        begin
                            fail      = 1'b1;
                            fail_code = nlsp_pkg::ERR_BAD_COMMA;
                        end
                        else if (depth_reg == 2'd1)
                        begin
                            if (32'(cnt_reg) + 32'd2 > 32'(nlsp_pkg::MAX_ENTRIES))
                            begin
                                fail      = 1'b1;
                                fail_code = nlsp_pkg::ERR_TOO_MANY;
                            end
                            else
                                cnt_next = cnt_reg + nlsp_pkg::CNT_W'(1);
                        end
                        else if (depth_reg == 2'd2)
                        begin
                            done_next = 1'b0;
                            if (pos_reg != nlsp_pkg::SLOT_BEYOND)
                                pos_next = pos_reg + 2'd1;
                        end
                    end
                    nlsp_pkg::CH_SPACE,
                    nlsp_pkg::CH_LF,
                    nlsp_pkg::CH_CR,
                    nlsp_pkg::CH_TAB:
                    begin
                        add_en = in_str_reg;
                    end
                    default:
                    begin
                        if (!in_str_reg)
                        begin
                            fail      = 1'b1;
                            fail_code = nlsp_pkg::ERR_BAD_CHAR;
                        end
                        else if (byte_req == nlsp_pkg::CH_BSLASH)
                            esc_next = 1'b1;
                        else
                            add_en = 1'b1;
                    end
                endcase
            end

            // one string character: length check, hash step, optional output
            if (add_en)
            begin
                if (32'(len_reg) >= nlsp_pkg::MAX_STRING_CHARS)
                begin
                    fail      = 1'b1;
                    fail_code = nlsp_pkg::ERR_TOO_LONG;
                end
                else
                begin
                    len_next   = len_reg + nlsp_pkg::LEN_W'(1);
                    stop       = hstop_reg || (add_c == nlsp_pkg::CH_NUL);
                    hstop_next = stop;
                    if (!stop)
                        hash_next = (hash_reg << 5) + hash_reg + nlsp_pkg::HASH_W'(add_c);
                    if (pos_reg == nlsp_pkg::SLOT_NAME || pos_reg == nlsp_pkg::SLOT_IMAGE)
                    begin
                        emit    = 1'b1;
                        rk_next = nlsp_pkg::RK_CHAR;
                        pl_next = nlsp_pkg::HASH_W'(add_c);
                    end
                end
            end

            if (fail)
            begin
                halted_next = 1'b1;
                emit        = 1'b1;
                rk_next     = nlsp_pkg::RK_ERROR;
                slot_next   = pos_reg;
                pl_next     = '0;
            end
        end

        if (fail)
            ec_next = fail_code;
        else
            ec_next = nlsp_pkg::ERR_TOO_DEEP;   // code 0 for non-error results

        if (accept)
            res_valid_next = emit;
        else if (res_ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg      <= '0;
            in_str_reg     <= 1'b0;
            entry_open_reg <= 1'b0;
            cnt_reg        <= '0;
            pos_reg        <= '0;
            done_reg       <= 1'b0;
            len_reg        <= '0;
            esc_reg        <= 1'b0;
            hash_reg       <= nlsp_pkg::HASH_SEED;
            halted_reg     <= 1'b0;
            hstop_reg      <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            depth_reg      <= depth_next;
            in_str_reg     <= in_str_next;
            entry_open_reg <= entry_open_next;
            cnt_reg        <= cnt_next;
            pos_reg        <= pos_next;
            done_reg       <= done_next;
            len_reg        <= len_next;
            esc_reg        <= esc_next;
            hash_reg       <= hash_next;
            halted_reg     <= halted_next;
            hstop_reg      <= hstop_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // result payload, loaded on a transfer that yields a result
    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            rk_reg   <= rk_next;
            num_reg  <= cnt_reg;
            slot_reg <= slot_next;
            pl_reg   <= pl_next;
            ec_reg   <= ec_next;
        end
    end

    assign res_valid    = res_valid_reg;
    assign result_kind  = rk_reg;
    assign entry_number = num_reg;
    assign value_slot   = slot_reg;
    assign payload      = pl_reg;
    assign error_code   = ec_reg;

endmodule

@@ hw/rtl/nlsp_checker.sv @@
// nlsp_checker: port-level assertions for nested_list_string_parser
// depends on nlsp_pkg; bound into nested_list_string_parser at the end of this file

module nlsp_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        kind,
    input logic [7:0]  byte_req,
    input logic        res_valid,
    input logic        res_ready,
    input logic [2:0]  result_kind,
    input logic [9:0]  entry_number,
    input logic [1:0]  value_slot,
    input logic [63:0] payload,
    input logic [3:0]  error_code
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(result_kind)
            && $stable(payload) && $stable(entry_number) && $stable(value_slot))
        else $error("stalled result changed");

    // only error results carry a nonzero code
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && result_kind != nlsp_pkg::RK_ERROR |-> error_code == 4'd0)
        else $error("error code on a non-error result");

    // key hash belongs to the key slot, string end to name or image
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && result_kind == nlsp_pkg::RK_END |->
            payload == 64'd0 && (value_slot == nlsp_pkg::SLOT_NAME
            || value_slot == nlsp_pkg::SLOT_IMAGE))
        else $error("string end in wrong slot");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && result_kind == nlsp_pkg::RK_HASH |-> value_slot == nlsp_pkg::SLOT_KEY)
        else $error("key hash outside key slot");

    // nothing follows a count or error transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && (result_kind == nlsp_pkg::RK_ERROR
            || result_kind == nlsp_pkg::RK_COUNT) |=> !res_valid)
        else $error("result after halt");

endmodule

bind nested_list_string_parser nlsp_checker u_nlsp_checker (.*);
